FILE: rtl/markov_miss_prefetcher_top_defines.svh
// ----------------------------------------------------------------------------
// Markov miss prefetcher assertion macros
// Shared concurrent assertion forms, clocked on aclk and gated by reset.
// ----------------------------------------------------------------------------
`ifndef MARKOV_MISS_PREFETCHER_TOP_DEFINES_SVH
`define MARKOV_MISS_PREFETCHER_TOP_DEFINES_SVH

// same-cycle implication
`define MMP_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) \
        (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define MMP_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) \
        (ante) |=> (cons)) else $error(msg);

`endif

FILE: rtl/mmp_pkg.sv
// ----------------------------------------------------------------------------
// mmp_pkg
// Widths, table geometry, register indexes and controller/datapath types.
// ----------------------------------------------------------------------------
`default_nettype none

package mmp_pkg;

    localparam int ADDR_W          = 48;
    localparam int PRIO_W          = 2;
    localparam int CNT_W           = 32;
    localparam int BSL_W           = 4;
    localparam int PSL_W           = 5;
    localparam int CFG_W           = 5;
    localparam int CFG_IDX_W       = 1;

    // row count kept a power of two so the row index is a bit slice
    localparam int TABLE_ROWS_LOG2 = 10;
    localparam int TABLE_ROWS      = 1 << TABLE_ROWS_LOG2;
    localparam int ROW_W           = TABLE_ROWS_LOG2;

    localparam int DEGREE          = 4;
    localparam int SLOT_W          = (DEGREE > 1) ? $clog2(DEGREE) : 1;
    localparam int XC_W            = $clog2(DEGREE + 1);
    localparam int MAX_RES         = 4;
    localparam int EMIT_W          = $clog2(MAX_RES);

    localparam logic [BSL_W-1:0] BSL_RESET = BSL_W'(6);
    localparam logic [PSL_W-1:0] PSL_RESET = PSL_W'(12);

    localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_SIZE_LOG2 = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_PAGE_SIZE_LOG2  = CFG_IDX_W'(1);

    typedef logic [DEGREE-1:0][ADDR_W-1:0] mmp_row_t;

    typedef struct packed {
        logic clr_step;   // write zero row, advance clear index
        logic ld_in;      // capture incoming miss word
        logic rd_prev;    // read row of previous miss
        logic learn_wr;   // write trained row back
        logic rd_cur;     // read row of current miss, retire previous
        logic scan;       // classify slots, update page-cross count
        logic emit;       // load one prefetch into output register
    } mmp_cmd_t;

    typedef struct packed {
        logic clr_last;
        logic same_addr;
        logic prev_nz;
        logic pend_any;
        logic out_free;
        logic emit_last;
    } mmp_sts_t;

endpackage

`default_nettype wire

FILE: rtl/markov_miss_prefetcher_top.sv
// Sequence: the previous miss's row is read and written back trained (skipped without a
//   previous miss), the new miss's row is read and scanned, then its prefetches follow one
//   per cycle while the output is not stalled. One miss at a time: the next is taken once
//   the last prefetch is loaded or none remain, or after the lookup for a repeated miss.
// Reset: synchronous, active low; the table is then swept clear, one row a cycle,
//   over all 1024 rows, during which no miss word is accepted.
// ----------------------------------------------------------------------------
// markov_miss_prefetcher_top
// Markov successor prefetcher: trains on miss pairs, issues same-page successors.
// ----------------------------------------------------------------------------
`default_nettype none

`include "markov_miss_prefetcher_top_defines.svh"

module markov_miss_prefetcher_top import mmp_pkg::*; (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 cfg_wr_en,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [CFG_W-1:0]     cfg_wdata,
    input  wire logic                 s_valid,
    output logic                      s_ready,
    input  wire logic [ADDR_W-1:0]    s_miss_address,
    output logic                      m_valid,
    input  wire logic                 m_ready,
    output logic      [ADDR_W-1:0]    m_prefetch_address,
    output logic      [PRIO_W-1:0]    m_priority_res,
    output logic      [CNT_W-1:0]     m_page_cross_total,
    output logic                      m_last
);

    mmp_cmd_t cmd;
    mmp_sts_t sts;

    mmp_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    mmp_datapath u_dp (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .cmd                (cmd),
        .sts                (sts),
        .cfg_wr_en          (cfg_wr_en),
        .cfg_index          (cfg_index),
        .cfg_wdata          (cfg_wdata),
        .s_miss_address     (s_miss_address),
        .m_valid            (m_valid),
        .m_ready            (m_ready),
        .m_prefetch_address (m_prefetch_address),
        .m_priority_res     (m_priority_res),
        .m_page_cross_total (m_page_cross_total),
        .m_last             (m_last)
    );

    `MMP_ASSERT_IMP(a_no_accept_in_clear, s_ready, !cmd.clr_step, "word accepted during clear")
    `MMP_ASSERT_NXT(a_one_at_a_time, s_valid && s_ready, !s_ready, "second miss taken early")
    `MMP_ASSERT_IMP(a_learn_after_read, cmd.learn_wr, $past(cmd.rd_prev), "train without row read")
    `MMP_ASSERT_NXT(a_out_hold, m_valid && !m_ready, m_valid && $stable(m_prefetch_address) && $stable(m_last), "stalled word changed")

endmodule

`default_nettype wire

FILE: rtl/mmp_ram.sv
// ----------------------------------------------------------------------------
// mmp_ram
// Simple dual-port RAM, one write and one read port, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module mmp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     aclk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        // read data holds between reads
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

FILE: rtl/mmp_ctrl.sv
// ----------------------------------------------------------------------------
// mmp_ctrl
// Sequencer: table clear after reset, then train / lookup / emit per miss.
// ----------------------------------------------------------------------------
`default_nettype none

module mmp_ctrl import mmp_pkg::*; (
    input  wire logic     aclk,
    input  wire logic     aresetn,
    input  wire logic     s_valid,
    output logic          s_ready,
    input  wire mmp_sts_t sts,
    output mmp_cmd_t      cmd
);

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_LOOKUP,
        ST_LEARN,
        ST_READ_CUR,
        ST_SCAN,
        ST_EMIT
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb begin
        cmd          = '0;
        cmd.clr_step = (state_reg == ST_CLEAR);
        cmd.ld_in    = (state_reg == ST_IDLE) && s_valid;
        cmd.rd_prev  = (state_reg == ST_LOOKUP) && !sts.same_addr && sts.prev_nz;
        cmd.learn_wr = (state_reg == ST_LEARN);
        cmd.rd_cur   = (state_reg == ST_READ_CUR);
        cmd.scan     = (state_reg == ST_SCAN);
        cmd.emit     = (state_reg == ST_EMIT) && sts.pend_any && sts.out_free;
        s_ready      = (state_reg == ST_IDLE);
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR: begin
                if (sts.clr_last) state_next = ST_IDLE;
            end
            ST_IDLE: begin
                if (s_valid) state_next = ST_LOOKUP;
            end
            ST_LOOKUP: begin
                if (sts.same_addr)    state_next = ST_IDLE;
                else if (sts.prev_nz) state_next = ST_LEARN;
                else                  state_next = ST_READ_CUR;
            end
            ST_LEARN:    state_next = ST_READ_CUR;
            ST_READ_CUR: state_next = ST_SCAN;
            ST_SCAN:     state_next = ST_EMIT;
            ST_EMIT: begin
                if (!sts.pend_any)                 state_next = ST_IDLE;
                else if (cmd.emit && sts.emit_last) state_next = ST_IDLE;
            end
            default:     state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_CLEAR;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/mmp_datapath.sv
// ----------------------------------------------------------------------------
// mmp_datapath
// Successor table, training and scan logic, config and output registers.
// ----------------------------------------------------------------------------
`default_nettype none

module mmp_datapath import mmp_pkg::*; (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire mmp_cmd_t             cmd,
    output mmp_sts_t                  sts,
    input  wire logic                 cfg_wr_en,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [CFG_W-1:0]     cfg_wdata,
    input  wire logic [ADDR_W-1:0]    s_miss_address,
    output logic                      m_valid,
    input  wire logic                 m_ready,
    output logic      [ADDR_W-1:0]    m_prefetch_address,
    output logic      [PRIO_W-1:0]    m_priority_res,
    output logic      [CNT_W-1:0]     m_page_cross_total,
    output logic                      m_last
);

    logic [BSL_W-1:0]  bsl_reg;
    logic [PSL_W-1:0]  psl_reg;
    logic [ADDR_W-1:0] addr_reg;
    logic [ADDR_W-1:0] prev_reg;
    logic [CNT_W-1:0]  pc_cnt_reg;
    logic [ROW_W-1:0]  clr_idx_reg;
    logic [DEGREE-1:0] pend_reg;
    logic [EMIT_W-1:0] emit_cnt_reg;
    logic              m_valid_reg;

    logic [ADDR_W-1:0] prev_shift;
    logic [ADDR_W-1:0] cur_shift;
    logic [ROW_W-1:0]  row_prev;
    logic [ROW_W-1:0]  row_cur;
    logic [ADDR_W-1:0] blk;
    logic [ADDR_W-1:0] blk_page;

    logic              ram_wr_en;
    logic [ROW_W-1:0]  ram_wr_addr;
    mmp_row_t          ram_wr_data;
    logic              ram_rd_en;
    logic [ROW_W-1:0]  ram_rd_addr;
    mmp_row_t          rd_row;
    mmp_row_t          learn_row;

    logic [DEGREE-1:0] match_vec;
    logic [DEGREE-1:0] cross_vec;
    logic [DEGREE-1:0] same_vec;
    logic [XC_W-1:0]   cross_cnt;
    logic [CNT_W:0]    pc_sum;
    logic [CNT_W-1:0]  pc_next;
    logic              seen;

    logic [SLOT_W-1:0] sel;
    logic [DEGREE-1:0] sel_mask;
    logic [DEGREE-1:0] pend_rest;
    logic [4:0]        prio_wide;
    logic              emit_last;

    // row index and block address
    assign prev_shift = prev_reg >> bsl_reg;
    assign cur_shift  = addr_reg >> bsl_reg;
    assign row_prev   = prev_shift[ROW_W-1:0];
    assign row_cur    = cur_shift[ROW_W-1:0];
    assign blk        = cur_shift << bsl_reg;
    assign blk_page   = blk >> psl_reg;

    // learn: move or push block to front of the recency list
    always_comb begin
        seen = 1'b0;
        for (int j = 0; j < DEGREE; j++) begin
            match_vec[j] = (rd_row[j] == blk);
        end
        learn_row[0] = blk;
        for (int j = 1; j < DEGREE; j++) begin
            seen         = seen | match_vec[j-1];
            learn_row[j] = seen ? rd_row[j] : rd_row[j-1];
        end
    end

    assign ram_wr_en   = cmd.clr_step | cmd.learn_wr;
    assign ram_wr_addr = cmd.clr_step ? clr_idx_reg : row_prev;
    assign ram_wr_data = cmd.clr_step ? '0 : learn_row;
    assign ram_rd_en   = cmd.rd_prev | cmd.rd_cur;
    assign ram_rd_addr = cmd.rd_prev ? row_prev : row_cur;

    mmp_ram #(
        .WIDTH (DEGREE * ADDR_W),
        .DEPTH (TABLE_ROWS)
    ) u_table (
        .aclk    (aclk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (rd_row)
    );

    // scan: empty slots are skipped, off-page slots only counted
    always_comb begin
        cross_cnt = '0;
        for (int d = 0; d < DEGREE; d++) begin
            cross_vec[d] = (rd_row[d] != '0) && ((rd_row[d] >> psl_reg) != blk_page);
            same_vec[d]  = (rd_row[d] != '0) && ((rd_row[d] >> psl_reg) == blk_page);
            cross_cnt    = cross_cnt + XC_W'(cross_vec[d]);
        end
        pc_sum  = {1'b0, pc_cnt_reg} + (CNT_W+1)'(cross_cnt);
        pc_next = pc_sum[CNT_W] ? '1 : pc_sum[CNT_W-1:0];
    end

    // lowest pending slot = most recent successor
    always_comb begin
        sel = '0;
        for (int d = DEGREE - 1; d >= 0; d--) begin
            if (pend_reg[d]) sel = SLOT_W'(d);
        end
        sel_mask      = '0;
        sel_mask[sel] = 1'b1;
        pend_rest     = pend_reg & ~sel_mask;
        prio_wide     = 5'(DEGREE - 1) - 5'(sel);
        emit_last     = (emit_cnt_reg == EMIT_W'(MAX_RES - 1)) || (pend_rest == '0);
    end

    always_comb begin
        sts           = '0;
        sts.clr_last  = (clr_idx_reg == ROW_W'(TABLE_ROWS - 1));
        sts.same_addr = (addr_reg == prev_reg);
        sts.prev_nz   = (prev_reg != '0);
        sts.pend_any  = (pend_reg != '0);
        sts.out_free  = !m_valid_reg || m_ready;
        sts.emit_last = emit_last;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bsl_reg      <= BSL_RESET;
            psl_reg      <= PSL_RESET;
            prev_reg     <= '0;
            pc_cnt_reg   <= '0;
            clr_idx_reg  <= '0;
            pend_reg     <= '0;
            emit_cnt_reg <= '0;
            m_valid_reg  <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                case (cfg_index)
                    CFG_BLOCK_SIZE_LOG2: bsl_reg <= cfg_wdata[BSL_W-1:0];
                    CFG_PAGE_SIZE_LOG2:  psl_reg <= cfg_wdata[PSL_W-1:0];
                    default: ;
                endcase
            end
            if (cmd.clr_step) clr_idx_reg <= clr_idx_reg + ROW_W'(1);
            if (cmd.rd_cur)   prev_reg    <= addr_reg;
            if (cmd.scan) begin
                pc_cnt_reg   <= pc_next;
                pend_reg     <= same_vec;
                emit_cnt_reg <= '0;
            end else if (cmd.emit) begin
                // drop the rest once the result cap is reached
                pend_reg     <= emit_last ? '0 : pend_rest;
                emit_cnt_reg <= emit_cnt_reg + EMIT_W'(1);
            end
            if (cmd.emit)        m_valid_reg <= 1'b1;
            else if (m_ready)    m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.ld_in) addr_reg <= s_miss_address;
        if (cmd.emit) begin
            m_prefetch_address <= rd_row[sel];
            m_priority_res     <= prio_wide[PRIO_W-1:0];
            m_page_cross_total <= pc_cnt_reg;
            m_last             <= emit_last;
        end
    end

    assign m_valid = m_valid_reg;

endmodule

`default_nettype wire

FILE: bench/tb_markov_miss_prefetcher_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_markov_miss_prefetcher_top
// Self-checking bench for the Markov miss prefetcher. A directed table of
// misses covers reset, extremes, repeats, zero addresses and full rows; then
// random phases replay short miss patterns under several block/page sizes.
// Every prefetch word is checked in order against a successor-table predictor
// or a typed row, with random stalls on both channels and one long output hold.
// ----------------------------------------------------------------------------

module tb_markov_miss_prefetcher_top import mmp_pkg::*;;

    localparam int LIMIT_CYCLES = 200000;
    localparam int HOLD_CYCLES  = 160;
    localparam int SETTLE       = 24;     // covers a full miss + 4 words
    localparam int PHASE_ITEMS  = 34;
    localparam int POOL_N       = 10;
    localparam int PAT_N        = 5;
    localparam int MAX_PRINT    = 100;

    typedef enum logic [1:0] {
        ROW_PREDICT,   // checked against the predictor
        ROW_SILENT,    // no prefetch expected
        ROW_SINGLE     // exactly one prefetch, typed below
    } row_kind_t;

    typedef struct packed {
        logic [ADDR_W-1:0] miss;
        row_kind_t         kind;
        logic [ADDR_W-1:0] pf;
        logic [PRIO_W-1:0] prio;
        logic [CNT_W-1:0]  total;
    } dir_row_t;

    typedef struct packed {
        logic [ADDR_W-1:0] pf;
        logic [PRIO_W-1:0] prio;
        logic [CNT_W-1:0]  total;
        logic              last;
    } pf_word_t;

    localparam int DIR_N = 24;
    // default sizes: 64 B blocks, 4 KB pages, row = addr[15:6]
    localparam dir_row_t DIR_ROWS [DIR_N] = '{
        '{48'h0,            ROW_SILENT,  48'h0,            2'd0, 32'd0}, // zero after reset
        '{48'h1000,         ROW_SILENT,  48'h0,            2'd0, 32'd0},
        '{48'h1040,         ROW_SILENT,  48'h0,            2'd0, 32'd0},
        '{48'h1040,         ROW_SILENT,  48'h0,            2'd0, 32'd0}, // repeat
        '{48'h1000,         ROW_SINGLE,  48'h1040,         2'd3, 32'd0},
        '{48'h1045,         ROW_SINGLE,  48'h1000,         2'd3, 32'd0},
        '{48'h3000,         ROW_SILENT,  48'h0,            2'd0, 32'd0},
        '{48'h1040,         ROW_SINGLE,  48'h1000,         2'd2, 32'd1}, // one crossing
        '{48'hFFFF_FFFF_FFFF, ROW_SILENT, 48'h0,           2'd0, 32'd0},
        '{48'hFFFF_FFFF_FFC5, ROW_SINGLE, 48'hFFFF_FFFF_FFC0, 2'd3, 32'd1},
        '{48'h0,            ROW_SILENT,  48'h0,            2'd0, 32'd0}, // learns block 0
        '{48'h1040,         ROW_PREDICT, 48'h0,            2'd0, 32'd0},
        '{48'hFFFF_FFFF_FFFF, ROW_PREDICT, 48'h0,          2'd0, 32'd0},
        // fill one row with four same-page successors
        '{48'h2000,         ROW_PREDICT, 48'h0,            2'd0, 32'd0},
        '{48'h2100,         ROW_PREDICT, 48'h0,            2'd0, 32'd0},
        '{48'h2000,         ROW_PREDICT, 48'h0,            2'd0, 32'd0},
        '{48'h2140,         ROW_PREDICT, 48'h0,            2'd0, 32'd0},
        '{48'h2000,         ROW_PREDICT, 48'h0,            2'd0, 32'd0},
        '{48'h2180,         ROW_PREDICT, 48'h0,            2'd0, 32'd0},
        '{48'h2000,         ROW_PREDICT, 48'h0,            2'd0, 32'd0},
        '{48'h21C0,         ROW_PREDICT, 48'h0,            2'd0, 32'd0},
        '{48'h2000,         ROW_PREDICT, 48'h0,            2'd0, 32'd0},
        '{48'h7FC0,         ROW_PREDICT, 48'h0,            2'd0, 32'd0},
        '{48'h2000,         ROW_PREDICT, 48'h0,            2'd0, 32'd0}
    };

    localparam int PHASE_N = 5;
    // block value 31 lands as 15 in the 4-bit register
    localparam logic [CFG_W-1:0] PHASE_BLK  [PHASE_N] = '{5'd4, 5'd8, 5'd31, 5'd0, 5'd6};
    localparam logic [CFG_W-1:0] PHASE_PAGE [PHASE_N] = '{5'd16, 5'd12, 5'd31, 5'd5, 5'd12};

    logic                 aclk;
    logic                 aresetn        = 1'b0;
    logic                 cfg_wr_en      = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index      = '0;
    logic [CFG_W-1:0]     cfg_wdata      = '0;
    logic                 s_valid        = 1'b0;
    logic                 s_ready;
    logic [ADDR_W-1:0]    s_miss_address = '0;
    logic                 m_valid;
    logic                 m_ready        = 1'b0;
    logic [ADDR_W-1:0]    m_prefetch_address;
    logic [PRIO_W-1:0]    m_priority_res;
    logic [CNT_W-1:0]     m_page_cross_total;
    logic                 m_last;

    // predictor state
    logic [ADDR_W-1:0]    succ_rows [TABLE_ROWS][DEGREE];
    logic [ADDR_W-1:0]    last_miss;
    logic [CNT_W-1:0]     cross_cnt;
    logic [BSL_W-1:0]     blk_log2;
    logic [PSL_W-1:0]     page_log2;

    pf_word_t             pending_pf [$];
    int                   mismatch_cnt = 0;
    int                   cycle_cnt    = 0;
    bit                   send_steady  = 1'b0;
    bit                   recv_steady  = 1'b0;
    bit                   hold_req     = 1'b0;

    markov_miss_prefetcher_top i_dut (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .cfg_wr_en          (cfg_wr_en),
        .cfg_index          (cfg_index),
        .cfg_wdata          (cfg_wdata),
        .s_valid            (s_valid),
        .s_ready            (s_ready),
        .s_miss_address     (s_miss_address),
        .m_valid            (m_valid),
        .m_ready            (m_ready),
        .m_prefetch_address (m_prefetch_address),
        .m_priority_res     (m_priority_res),
        .m_page_cross_total (m_page_cross_total),
        .m_last             (m_last)
    );

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == LIMIT_CYCLES) begin
            $display("timeout after %0d cycles", cycle_cnt);
            $display("** markov_miss_prefetcher_top: FAILED **");
            $finish;
        end
    end

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        if (mismatch_cnt < MAX_PRINT)
            $display("%0t: %s: got 0x%0h, want 0x%0h", $realtime, what, got, want);
        mismatch_cnt++;
    endtask

    function automatic int row_of(input logic [ADDR_W-1:0] a);
        logic [ADDR_W-1:0] sh;
        sh = a >> blk_log2;
        return int'(sh[ROW_W-1:0]);
    endfunction

    function automatic logic [ADDR_W-1:0] rand_addr();
        logic [63:0] r;
        r = {$urandom, $urandom};
        return r[ADDR_W-1:0];
    endfunction

    // move blk to the front of the row, dropping the oldest slot on a miss
    task automatic learn_successor(input int row, input logic [ADDR_W-1:0] blk);
        int hit;
        int j;
        hit = DEGREE - 1;
        for (j = DEGREE - 1; j >= 0; j--)
            if (succ_rows[row][j] == blk) hit = j;
        for (j = hit; j > 0; j--)
            succ_rows[row][j] = succ_rows[row][j - 1];
        succ_rows[row][0] = blk;
    endtask

    // advance the predictor by one accepted miss; queue its prefetches if keep
    task automatic predict_prefetches(input logic [ADDR_W-1:0] miss, input bit keep,
                                      output bit repeated);
        logic [ADDR_W-1:0] blk;
        logic [ADDR_W-1:0] cand;
        logic [ADDR_W-1:0] hits [$];
        logic [PRIO_W-1:0] prios [$];
        pf_word_t          w;
        int                row;
        int                d;
        int                k;
        blk = miss & ~((ADDR_W'(1) << blk_log2) - ADDR_W'(1));
        repeated = (miss == last_miss);
        if (!repeated) begin
            if (last_miss != '0)
                learn_successor(row_of(last_miss), blk);
            last_miss = miss;
            row = row_of(miss);
            for (d = 0; d < DEGREE; d++) begin
                cand = succ_rows[row][d];
                if (cand != '0) begin
                    if ((cand >> page_log2) != (blk >> page_log2)) begin
                        if (cross_cnt != '1) cross_cnt++;
                    end else if (hits.size() < MAX_RES) begin
                        hits  = {hits, cand};
                        prios = {prios, PRIO_W'(DEGREE - 1 - d)};
                    end
                end
            end
            if (keep) begin
                for (k = 0; k < hits.size(); k++) begin
                    w.pf    = hits[k];
                    w.prio  = prios[k];
                    w.total = cross_cnt;
                    w.last  = (k == hits.size() - 1);
                    pending_pf = {pending_pf, w};
                end
            end
        end
    endtask

    task automatic send_miss(input logic [ADDR_W-1:0] miss);
        int gap;
        gap = 0;
        if (!send_steady)
            while ($urandom_range(0, 99) < 38) gap++;
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid        <= 1'b1;
        s_miss_address <= miss;
        do @(posedge aclk); while (!s_ready);
    endtask

    task automatic wait_drained();
        int guard;
        guard = 0;
        while (pending_pf.size() != 0 && guard < 20000) begin
            @(posedge aclk);
            guard++;
        end
        repeat (SETTLE) @(posedge aclk);
    endtask

    task automatic write_config(input logic [CFG_W-1:0] blk_val,
                                input logic [CFG_W-1:0] page_val);
        cfg_wr_en <= 1'b1;
        cfg_index <= CFG_BLOCK_SIZE_LOG2;
        cfg_wdata <= blk_val;
        @(posedge aclk);
        cfg_index <= CFG_PAGE_SIZE_LOG2;
        cfg_wdata <= page_val;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        blk_log2  = blk_val[BSL_W-1:0];
        page_log2 = page_val;
    endtask

    // output side: random stalls, or one long hold when asked
    initial begin
        forever begin
            @(posedge aclk);
            if (hold_req) begin
                hold_req = 1'b0;
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
            end else begin
                m_ready <= recv_steady || ($urandom_range(0, 99) >= 38);
            end
        end
    end

    always @(posedge aclk) begin : check_prefetch
        pf_word_t w;
        if (aresetn && m_valid && m_ready) begin
            if (pending_pf.size() == 0) begin
                report_mismatch("prefetch word with nothing pending",
                                64'(m_prefetch_address), 64'h0);
            end else begin
                w = pending_pf.pop_front();
                if (m_prefetch_address !== w.pf)
                    report_mismatch("prefetch_address", 64'(m_prefetch_address), 64'(w.pf));
                if (m_priority_res !== w.prio)
                    report_mismatch("priority_res", 64'(m_priority_res), 64'(w.prio));
                if (m_page_cross_total !== w.total)
                    report_mismatch("page_cross_total", 64'(m_page_cross_total),
                                    64'(w.total));
                if (m_last !== w.last)
                    report_mismatch("last", 64'(m_last), 64'(w.last));
            end
        end
    end

    initial begin : stimulus
        logic [ADDR_W-1:0] pool [POOL_N];
        int                pat  [PAT_N];
        logic [ADDR_W-1:0] miss;
        pf_word_t          w;
        bit                repeated;
        int                i;
        int                p;
        int                sent;
        int                pat_pos;
        int                sel;

        for (i = 0; i < TABLE_ROWS; i++)
            for (p = 0; p < DEGREE; p++) succ_rows[i][p] = '0;
        last_miss = '0;
        cross_cnt = '0;
        blk_log2  = BSL_RESET;
        page_log2 = PSL_RESET;

        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        // directed table under reset sizes
        for (i = 0; i < DIR_N; i++) begin
            send_miss(DIR_ROWS[i].miss);
            predict_prefetches(DIR_ROWS[i].miss, DIR_ROWS[i].kind == ROW_PREDICT, repeated);
            if (DIR_ROWS[i].kind == ROW_SINGLE) begin
                w.pf    = DIR_ROWS[i].pf;
                w.prio  = DIR_ROWS[i].prio;
                w.total = DIR_ROWS[i].total;
                w.last  = 1'b1;
                pending_pf = {pending_pf, w};
            end
        end
        s_valid <= 1'b0;

        for (p = 0; p < PHASE_N; p++) begin
            wait_drained();
            write_config(PHASE_BLK[p], PHASE_PAGE[p]);
            send_steady = (p <= 1);
            recv_steady = (p == 1);
            if (p == 0) hold_req = 1'b1;   // back up the block, input must stall

            pool[0] = rand_addr();
            for (i = 1; i < POOL_N; i++) begin
                pool[i] = pool[0] ^ (ADDR_W'($urandom_range(1, 31)) << blk_log2);
                if (i >= POOL_N - 2)
                    pool[i] = pool[i] ^ (ADDR_W'(1) << page_log2);
            end
            for (i = 0; i < PAT_N; i++) pat[i] = $urandom_range(0, POOL_N - 1);

            pat_pos = 0;
            sent    = 0;
            while (sent < PHASE_ITEMS) begin
                sel = $urandom_range(0, 99);
                if (sel < 65) begin
                    miss    = pool[pat[pat_pos]];
                    pat_pos = (pat_pos + 1) % PAT_N;
                end else if (sel < 80) begin
                    miss = pool[$urandom_range(0, POOL_N - 1)];
                end else if (sel < 92) begin
                    miss = rand_addr();
                end else if (sel < 95) begin
                    miss = '0;
                end else begin
                    miss = last_miss;
                end
                send_miss(miss);
                predict_prefetches(miss, 1'b1, repeated);
                if (!repeated) sent++;
            end
            s_valid <= 1'b0;
        end

        wait_drained();
        while (pending_pf.size() != 0) begin
            w = pending_pf.pop_front();
            report_mismatch("prefetch never issued", 64'(w.pf), 64'(w.pf));
        end
        if (mismatch_cnt == 0)
            $display("** markov_miss_prefetcher_top: PASSED **");
        else
            $display("** markov_miss_prefetcher_top: FAILED **");
        $finish;
    end

endmodule
